/* rtl/qst_pkg.sv */
package qst_pkg;

    localparam int BALANCE_BITS_DEFAULT = 17;
    localparam int MAX_RESULTS          = 3;
    localparam int QUEUE_DEPTH          = 8;
    localparam int QUEUE_PTR_BITS       = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_PAIR_DELIM   = 2'd0;
    localparam logic [1:0] CFG_KEYVAL_DELIM = 2'd1;
    localparam logic [1:0] CFG_SKIP_SPACES  = 2'd2;

    localparam logic [2:0] KIND_KEY_BYTE   = 3'd0;
    localparam logic [2:0] KIND_VALUE_BYTE = 3'd1;
    localparam logic [2:0] KIND_END_KEY    = 3'd2;
    localparam logic [2:0] KIND_END_PAIR   = 3'd3;
    localparam logic [2:0] KIND_STATUS     = 3'd4;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_EMPTY       = 3'd1;
    localparam logic [2:0] STATUS_MISMATCH    = 3'd2;
    localparam logic [2:0] STATUS_STRAY_KV    = 3'd3;
    localparam logic [2:0] STATUS_STRAY_PAIR  = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
        logic       in_empty;
    } in_item_t;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] out_status;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                   count;
        out_item_t [MAX_RESULTS-1:0]  item;
    } step_res_t;

    function automatic out_item_t make_item(
        input logic [2:0] kind,
        input logic [7:0] data,
        input logic [2:0] status,
        input logic       last
    );
        out_item_t r;
        r.out_kind   = kind;
        r.out_byte   = data;
        r.out_status = status;
        r.out_last   = last;
        return r;
    endfunction

endpackage

/* rtl/query_string_tokenizer.sv */
// channel  direction  payload        handshake
// in       input      in_item_t      in_valid / in_stall
// out      output     out_item_t     out_valid / out_stall
// cfg      input      cfg_data[7:0]  cfg_we, cfg_index[1:0]
//
// one byte per cycle while the result queue has room; a taken byte is held in the
// input register, parsed from there into the result queue, and offered from its head
// a byte gives up to three results; they leave through the single output port at one
// per cycle while out_stall is low; input stalls while under three queue slots are free
// rst_n clears the parse state, the queue and the config registers to their defaults
module query_string_tokenizer #(
    parameter int BALANCE_BITS = qst_pkg::BALANCE_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  qst_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output qst_pkg::out_item_t  out_item
);

    logic               in_valid_reg;
    qst_pkg::in_item_t  in_item_reg;
    logic               room;
    logic               advance;
    qst_pkg::step_res_t step_res;

    assign advance  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
    end

    qst_core #(
        .BALANCE_BITS (BALANCE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .item      (in_item_reg),
        .res       (step_res)
    );

    qst_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step_res),
        .pop        (out_valid && !out_stall),
        .room       (room),
        .head_valid (out_valid),
        .head       (out_item)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.out_last == (out_item.out_kind == qst_pkg::KIND_STATUS)))
        else $error("last flag not on the final status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.out_kind != qst_pkg::KIND_STATUS)
            |-> (out_item.out_status == qst_pkg::STATUS_OK))
        else $error("status set on a token transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.out_kind == qst_pkg::KIND_END_KEY
            || out_item.out_kind == qst_pkg::KIND_END_PAIR
            || out_item.out_kind == qst_pkg::KIND_STATUS))
            |-> (out_item.out_byte == 8'd0))
        else $error("mark carries a byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !room) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input item lost");

endmodule

/* rtl/qst_core.sv */
module qst_core #(
    parameter int BALANCE_BITS = qst_pkg::BALANCE_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                step_en,
    input  qst_pkg::in_item_t   item,
    output qst_pkg::step_res_t  res
);

    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [9:0] DECODE_CLAMP = 10'd127;

    localparam logic [BALANCE_BITS-1:0] BAL_ONE = BALANCE_BITS'(1);

    logic [7:0]              pair_delim_reg;
    logic [7:0]              keyval_delim_reg;
    logic                    skip_spaces_reg;

    logic                    in_key_reg, in_key_next;
    logic                    tok_started_reg, tok_started_next;
    logic [1:0]              esc_reg, esc_next;
    logic [5:0]              first_digit_reg, first_digit_next;
    logic [BALANCE_BITS-1:0] balance_reg, balance_next;
    logic                    spaces_only_reg, spaces_only_next;
    logic [2:0]              error_reg, error_next;

    function automatic logic [5:0] digit_value(input logic [7:0] b);
        logic [5:0] d;
        d = 6'd0;
        if (b >= 8'h30 && b <= 8'h39)
            d = 6'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h7a)
            d = 6'(b - 8'h61 + 8'd10);
        else if (b >= 8'h41 && b <= 8'h5a)
            d = 6'(b - 8'h41 + 8'd10);
        return d;
    endfunction

    always_comb
    begin
        logic [1:0] n;
        logic       content;
        logic [7:0] b;
        logic [9:0] decoded;
        logic [2:0] status;

        in_key_next      = in_key_reg;
        tok_started_next = tok_started_reg;
        esc_next         = esc_reg;
        first_digit_next = first_digit_reg;
        balance_next     = balance_reg;
        spaces_only_next = spaces_only_reg;
        error_next       = error_reg;
        res              = '0;
        n                = 2'd0;
        content          = 1'b0;
        b                = item.in_byte;
        decoded          = {first_digit_reg, 4'b0000} + 10'(digit_value(b));
        status           = qst_pkg::STATUS_OK;

        if (step_en)
        begin
            if (!item.in_empty)
            begin
                if (b != CHAR_SPACE)
                    spaces_only_next = 1'b0;
                if (b == pair_delim_reg)
                    balance_next = balance_reg - BAL_ONE;
                else if (b == keyval_delim_reg)
                    balance_next = balance_reg + BAL_ONE;

                if (error_reg == qst_pkg::STATUS_OK)
                begin
                    if (skip_spaces_reg && b == CHAR_SPACE)
                    begin
                        content = tok_started_reg;
                    end
                    else if (b == keyval_delim_reg)
                    begin
                        if (!in_key_reg)
                            error_next = qst_pkg::STATUS_STRAY_KV;
                        else
                        begin
                            res.item[n] = qst_pkg::make_item(qst_pkg::KIND_END_KEY,
                                8'd0, qst_pkg::STATUS_OK, 1'b0);
                            n = n + 2'd1;
                            in_key_next      = 1'b0;
                            tok_started_next = 1'b0;
                        end
                    end
                    else if (b == pair_delim_reg)
                    begin
                        if (in_key_reg)
                            error_next = qst_pkg::STATUS_STRAY_PAIR;
                        else
                        begin
                            if (esc_reg != ESC_NONE)
                            begin
                                res.item[n] = qst_pkg::make_item(qst_pkg::KIND_VALUE_BYTE,
                                    CHAR_PERCENT, qst_pkg::STATUS_OK, 1'b0);
                                n = n + 2'd1;
                            end
                            esc_next         = ESC_NONE;
                            first_digit_next = 6'd0;
                            res.item[n] = qst_pkg::make_item(qst_pkg::KIND_END_PAIR,
                                8'd0, qst_pkg::STATUS_OK, 1'b0);
                            n = n + 2'd1;
                            in_key_next      = 1'b1;
                            tok_started_next = 1'b0;
                        end
                    end
                    else
                    begin
                        content = 1'b1;
                    end

                    if (content)
                    begin
                        tok_started_next = 1'b1;
                        if (in_key_reg)
                        begin
                            res.item[n] = qst_pkg::make_item(qst_pkg::KIND_KEY_BYTE,
                                b, qst_pkg::STATUS_OK, 1'b0);
                            n = n + 2'd1;
                        end
                        else if (esc_reg == ESC_FIRST)
                        begin
                            first_digit_next = digit_value(b);
                            esc_next         = ESC_SECOND;
                        end
                        else if (esc_reg == ESC_SECOND)
                        begin
                            if (decoded > DECODE_CLAMP)
                                decoded = DECODE_CLAMP;
                            res.item[n] = qst_pkg::make_item(qst_pkg::KIND_VALUE_BYTE,
                                decoded[7:0], qst_pkg::STATUS_OK, 1'b0);
                            n = n + 2'd1;
                            esc_next         = ESC_NONE;
                            first_digit_next = 6'd0;
                        end
                        else if (b == CHAR_PLUS)
                        begin
                            res.item[n] = qst_pkg::make_item(qst_pkg::KIND_VALUE_BYTE,
                                CHAR_SPACE, qst_pkg::STATUS_OK, 1'b0);
                            n = n + 2'd1;
                        end
                        else if (b == CHAR_PERCENT)
                        begin
                            esc_next = ESC_FIRST;
                        end
                        else
                        begin
                            res.item[n] = qst_pkg::make_item(qst_pkg::KIND_VALUE_BYTE,
                                b, qst_pkg::STATUS_OK, 1'b0);
                            n = n + 2'd1;
                        end
                    end
                end
            end

            if (item.in_last)
            begin
                // close an open value before the final status
                if (error_next == qst_pkg::STATUS_OK && !in_key_next)
                begin
                    if (esc_next != ESC_NONE)
                    begin
                        res.item[n] = qst_pkg::make_item(qst_pkg::KIND_VALUE_BYTE,
                            CHAR_PERCENT, qst_pkg::STATUS_OK, 1'b0);
                        n = n + 2'd1;
                    end
                    res.item[n] = qst_pkg::make_item(qst_pkg::KIND_END_PAIR,
                        8'd0, qst_pkg::STATUS_OK, 1'b0);
                    n = n + 2'd1;
                end

                if (skip_spaces_reg && spaces_only_next)
                    status = qst_pkg::STATUS_EMPTY;
                else if (balance_next != BAL_ONE)
                    status = qst_pkg::STATUS_MISMATCH;
                else
                    status = error_next;

                res.item[n] = qst_pkg::make_item(qst_pkg::KIND_STATUS, 8'd0, status, 1'b1);
                n = n + 2'd1;

                in_key_next      = 1'b1;
                tok_started_next = 1'b0;
                esc_next         = ESC_NONE;
                first_digit_next = 6'd0;
                balance_next     = '0;
                spaces_only_next = 1'b1;
                error_next       = qst_pkg::STATUS_OK;
            end
        end

        res.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_delim_reg   <= 8'd38;
            keyval_delim_reg <= 8'd61;
            skip_spaces_reg  <= 1'b0;
            in_key_reg       <= 1'b1;
            tok_started_reg  <= 1'b0;
            esc_reg          <= ESC_NONE;
            first_digit_reg  <= 6'd0;
            balance_reg      <= '0;
            spaces_only_reg  <= 1'b1;
            error_reg        <= qst_pkg::STATUS_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    qst_pkg::CFG_PAIR_DELIM:   pair_delim_reg   <= cfg_data;
                    qst_pkg::CFG_KEYVAL_DELIM: keyval_delim_reg <= cfg_data;
                    qst_pkg::CFG_SKIP_SPACES:  skip_spaces_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            in_key_reg      <= in_key_next;
            tok_started_reg <= tok_started_next;
            esc_reg         <= esc_next;
            first_digit_reg <= first_digit_next;
            balance_reg     <= balance_next;
            spaces_only_reg <= spaces_only_next;
            error_reg       <= error_next;
        end
    end

endmodule

/* rtl/qst_result_queue.sv */
module qst_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  qst_pkg::step_res_t  push,
    input  logic                pop,
    output logic                room,
    output logic                head_valid,
    output qst_pkg::out_item_t  head
);

    localparam int PtrW = qst_pkg::QUEUE_PTR_BITS;
    localparam int CntW = qst_pkg::QUEUE_PTR_BITS + 1;
    localparam logic [CntW-1:0] ROOM_LIMIT =
        CntW'(qst_pkg::QUEUE_DEPTH - qst_pkg::MAX_RESULTS);
    localparam logic [CntW-1:0] FULL_COUNT = CntW'(qst_pkg::QUEUE_DEPTH);

    qst_pkg::out_item_t mem [qst_pkg::QUEUE_DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign room       = (count_reg <= ROOM_LIMIT);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < qst_pkg::MAX_RESULTS; i++)
        begin
            if (2'(i) < push.count)
                mem[wr_ptr_reg + PtrW'(i)] <= push.item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PtrW'(pop);
            count_reg  <= count_reg + CntW'(push.count) - CntW'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("result queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

endmodule
